### design/rmt_pkg.sv
// Shared types, constants and helpers for the range max table.
`timescale 1ns / 1ps
`default_nettype none

package rmt_pkg;

    localparam int POSITIONS_DEF = 1024;

    localparam logic signed [31:0] NEG_INF = -32'sd1061109567;

    // generation tag width; a clear bumps the generation
    localparam int GEN_W = 8;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [GEN_W-1:0]   tag;
        logic signed [31:0] val;
    } t_node;

    typedef struct packed {
        logic rd_a;
        logic rd_b;
        logic wr;
    } t_ram_ctl;

    function automatic logic signed [31:0] max_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        max_s = (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

### design/rmt_node_ram.sv
// Tree node memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module rmt_node_ram
    import rmt_pkg::*;
#(
    parameter int POSITIONS = POSITIONS_DEF
) (
    input  wire logic                         i_clk,
    input  wire t_ram_ctl                     i_ctl,
    input  wire logic [$clog2(POSITIONS):0]   i_rd_a_addr,
    input  wire logic [$clog2(POSITIONS):0]   i_rd_b_addr,
    input  wire logic [$clog2(POSITIONS):0]   i_wr_addr,
    input  wire t_node                        i_wr_data,
    output t_node                             o_rd_a_data,
    output t_node                             o_rd_b_data
);

    localparam int NW    = $clog2(POSITIONS) + 1;
    localparam int DEPTH = 1 << NW;

    t_node mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_a) begin
            o_rd_a_data <= mem[i_rd_a_addr];
        end
        if (i_ctl.rd_b) begin
            o_rd_b_data <= mem[i_rd_b_addr];
        end
    end

endmodule

`default_nettype wire

### design/rmt_walker.sv
// Tree walker: clearing sweep, leaf-to-root update, bottom-up range query.
`timescale 1ns / 1ps
`default_nettype none

module rmt_walker
    import rmt_pkg::*;
#(
    parameter int POSITIONS = POSITIONS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [1:0]                 i_operation,
    input  wire logic [10:0]                i_position,
    input  wire logic signed [31:0]         i_value,
    input  wire logic signed [11:0]         i_query_low,
    input  wire logic signed [11:0]         i_query_high,
    input  wire logic signed [31:0]         i_zero_slot,
    output logic                            o_busy,
    output logic                            o_res_valid,
    output logic signed [31:0]              o_res,
    input  wire logic                       i_res_take,
    output t_ram_ctl                        o_ctl,
    output logic [$clog2(POSITIONS):0]      o_rd_a_addr,
    output logic [$clog2(POSITIONS):0]      o_rd_b_addr,
    output logic [$clog2(POSITIONS):0]      o_wr_addr,
    output t_node                           o_wr_data,
    input  wire t_node                      i_rd_a_data,
    input  wire t_node                      i_rd_b_data
);

    localparam int LVL = $clog2(POSITIONS);
    localparam int NW  = LVL + 1;
    localparam int BW  = LVL + 2;
    localparam logic signed [31:0] POS_S = 32'(POSITIONS);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_QRY   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [GEN_W-1:0]   r_gen, n_gen;
    logic               r_sweep_neg, n_sweep_neg;
    logic [NW-1:0]      r_waddr, n_waddr;
    logic [NW-1:0]      r_addr, n_addr;
    logic               r_pend, n_pend;
    logic signed [31:0] r_val, n_val;
    logic [BW-1:0]      r_l, n_l;
    logic [BW-1:0]      r_r, n_r;
    logic               r_qa, n_qa;
    logic               r_qb, n_qb;
    logic signed [31:0] r_acc, n_acc;
    logic               r_zero_only, n_zero_only;
    logic               r_zero_incl, n_zero_incl;

    logic signed [31:0] eff_a, eff_b, fold;
    logic signed [31:0] pos_s, ql_s, qh_s, lo_s, hi_s, lo_m1, hi_m1;
    logic               pos_ok;
    logic [BW-1:0]      r_m1;
    logic               clr_acc;

    function automatic logic [LVL-1:0] pos_m1_bits(input logic signed [31:0] p);
        logic signed [31:0] m;
        m = p - 32'sd1;
        pos_m1_bits = m[LVL-1:0];
    endfunction

    assign eff_a = (i_rd_a_data.tag == r_gen) ? i_rd_a_data.val : NEG_INF;
    assign eff_b = (i_rd_b_data.tag == r_gen) ? i_rd_b_data.val : NEG_INF;

    assign pos_s  = {21'd0, i_position};
    assign pos_ok = (pos_s >= 32'sd1) && (pos_s <= POS_S);
    assign ql_s   = {{20{i_query_low[11]}}, i_query_low};
    assign qh_s   = {{20{i_query_high[11]}}, i_query_high};
    assign lo_s   = (ql_s < 32'sd1) ? 32'sd1 : ql_s;
    assign hi_s   = (qh_s > POS_S) ? POS_S : qh_s;
    assign lo_m1  = lo_s - 32'sd1;
    assign hi_m1  = hi_s - 32'sd1;
    assign r_m1   = r_r - BW'(1);

    assign clr_acc = (r_state == S_IDLE) && i_valid && (i_operation == OP_CLEAR);

    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_sweep_neg = r_sweep_neg;
        n_waddr     = r_waddr;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_val       = r_val;
        n_l         = r_l;
        n_r         = r_r;
        n_qa        = r_qa;
        n_qb        = r_qb;
        n_acc       = r_acc;
        n_zero_only = r_zero_only;
        n_zero_incl = r_zero_incl;
        o_ctl       = '0;
        o_rd_a_addr = r_addr;
        o_rd_b_addr = r_m1[NW-1:0];
        o_wr_addr   = r_waddr;
        o_wr_data   = '{tag: r_gen, val: max_s(eff_a, r_val)};
        fold        = r_acc;
        if (r_qa) begin
            fold = max_s(fold, eff_a);
        end
        if (r_qb) begin
            fold = max_s(fold, eff_b);
        end

        case (r_state)
            S_SWEEP: begin
                o_ctl.wr  = 1'b1;
                o_wr_data = '{tag: '0, val: (r_sweep_neg ? NEG_INF : 32'sd0)};
                n_waddr   = r_waddr + NW'(1);
                if (&r_waddr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_operation)
                        OP_UPDATE: begin
                            if (pos_ok) begin
                                n_addr  = {1'b1, pos_m1_bits(pos_s)};
                                n_pend  = 1'b0;
                                n_val   = i_value;
                                n_state = S_UPD;
                            end
                        end
                        OP_QUERY: begin
                            n_acc       = NEG_INF;
                            n_qa        = 1'b0;
                            n_qb        = 1'b0;
                            n_zero_only = (qh_s == 32'sd0);
                            n_zero_incl = (qh_s > 32'sd0) && (ql_s < 32'sd1);
                            if ((qh_s > 32'sd0) && (lo_s <= hi_s)) begin
                                n_l = {2'b01, lo_m1[LVL-1:0]};
                                n_r = {2'b01, hi_m1[LVL-1:0]} + BW'(1);
                            end else begin
                                n_l = '0;
                                n_r = '0;
                            end
                            n_state = S_QRY;
                        end
                        OP_CLEAR: begin
                            if (&r_gen) begin
                                n_gen       = '0;
                                n_sweep_neg = 1'b1;
                                n_waddr     = '0;
                                n_state     = S_SWEEP;
                            end else begin
                                n_gen = r_gen + GEN_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_UPD: begin
                o_ctl.wr = r_pend;
                if (r_addr != '0) begin
                    o_ctl.rd_a = 1'b1;
                    n_waddr    = r_addr;
                    n_addr     = r_addr >> 1;
                    n_pend     = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_QRY: begin
                n_acc = fold;
                if (r_l < r_r) begin
                    o_ctl.rd_a  = r_l[0];
                    o_ctl.rd_b  = r_r[0];
                    o_rd_a_addr = r_l[NW-1:0];
                    n_qa        = r_l[0];
                    n_qb        = r_r[0];
                    n_l         = (r_l + BW'(r_l[0])) >> 1;
                    n_r         = (r_r - BW'(r_r[0])) >> 1;
                end else begin
                    n_qa    = 1'b0;
                    n_qb    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_zero_only ? i_zero_slot :
                         (r_zero_incl ? max_s(r_acc, i_zero_slot) : r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_gen       <= '0;
            r_sweep_neg <= 1'b0;
            r_waddr     <= '0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_sweep_neg <= n_sweep_neg;
            r_waddr     <= n_waddr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pend      <= n_pend;
        r_val       <= n_val;
        r_l         <= n_l;
        r_r         <= n_r;
        r_qa        <= n_qa;
        r_qb        <= n_qb;
        r_acc       <= n_acc;
        r_zero_only <= n_zero_only;
        r_zero_incl <= n_zero_incl;
    end

    a_no_rw_same_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.wr && o_ctl.rd_a) |-> (o_wr_addr != o_rd_a_addr))
        else $error("read and write of the same node in one cycle");

    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRY) |-> (r_l <= r_r))
        else $error("query bounds crossed");

    a_gen_only_on_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clr_acc |=> $stable(r_gen))
        else $error("generation changed without a clear");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWEEP) && (&r_waddr)) |=> (r_state == S_IDLE))
        else $error("sweep did not end at the last node");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_ctl.wr)
        else $error("memory write while idle");

endmodule

`default_nettype wire

### design/range_max_table_with_clear.sv
// Top level of the range max table with lazy clear.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_operation, i_position, i_value,
//          |           |                            | i_query_low, i_query_high
//  out     | output    | o_out_valid / i_out_stall  | o_max_value
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (zero_slot_value)
//
// Update: one tree level per cycle (read, max, write back).
// Query: one level per cycle on two memory read ports.
// Clear: a generation bump; every 2**8-th clear runs a sweep over all 2*span nodes instead.
// After reset a sweep over all 2*span nodes (span = POSITIONS rounded up to a power of two)
// zeroes the memory; o_in_stall stays high meanwhile. One item at a time; a query
// result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module range_max_table_with_clear
    import rmt_pkg::*;
#(
    parameter int POSITIONS = POSITIONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_operation,
    input  wire logic [10:0]        i_position,
    input  wire logic signed [31:0] i_value,
    input  wire logic signed [11:0] i_query_low,
    input  wire logic signed [11:0] i_query_high,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_max_value,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic signed [30:0] i_cfg_data
);

    localparam int NW = $clog2(POSITIONS) + 1;

    logic signed [30:0] r_zero_slot;
    logic               r_out_valid;
    logic signed [31:0] r_out_data;

    logic               busy, res_valid, res_take;
    logic signed [31:0] res;
    t_ram_ctl           ctl;
    logic [NW-1:0]      rd_a_addr, rd_b_addr, wr_addr;
    t_node              wr_data, rd_a_data, rd_b_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_max_value = r_out_data;
    assign res_take    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_slot <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_zero_slot <= i_cfg_data;
            end
            if (res_valid && res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out_data <= res;
        end
    end

    rmt_walker #(
        .POSITIONS(POSITIONS)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_query_low  (i_query_low),
        .i_query_high (i_query_high),
        .i_zero_slot  ({r_zero_slot[30], r_zero_slot}),
        .o_busy       (busy),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take),
        .o_ctl        (ctl),
        .o_rd_a_addr  (rd_a_addr),
        .o_rd_b_addr  (rd_b_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_rd_a_data  (rd_a_data),
        .i_rd_b_data  (rd_b_data)
    );

    rmt_node_ram #(
        .POSITIONS(POSITIONS)
    ) u_ram (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_rd_a_addr (rd_a_addr),
        .i_rd_b_addr (rd_b_addr),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_rd_a_data (rd_a_data),
        .o_rd_b_data (rd_b_data)
    );

endmodule

`default_nettype wire
